FILE: hw/rtl/blre_pkg.sv
// ----------------------------------------------------------------------------
// blre_pkg: shared types and constants of the bilevel run-length extractor
// Field widths, the register reset value and the run record that carries
// one result between the run finder, the result buffer and the output.
// ----------------------------------------------------------------------------
package blre_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W = 11;
  localparam int RUN_W = 14;
  localparam int MAX_RUNS = 9;
  localparam int CNT_W = $clog2(MAX_RUNS + 1);
  localparam int PTR_W = $clog2(MAX_RUNS);
  localparam int DEF_MAX_LINE_BYTES = 1024;

  localparam logic [CFG_W-1:0] LINE_BYTES_RESET = CFG_W'(216);
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef struct packed {
    logic [RUN_W-1:0] length;
    logic             color;
    logic             last;
  } run_t;

endpackage

FILE: hw/rtl/bilevel_line_run_length_extractor_core.sv
// ----------------------------------------------------------------------------
// bilevel_line_run_length_extractor_core: scan-line run-length extractor
// Turns packed 1-bit pixel bytes into alternating white and black runs.
// ----------------------------------------------------------------------------
// A byte of eight pixels (MSB first, 1 is black) is taken per beat. Each line
// opens with a white run, so a line starting in black first yields a
// zero-length white run; the run still open after cfg line_bytes bytes (0
// acts as 1, values above MAX_LINE_BYTES act as MAX_LINE_BYTES) is sent with
// out_line_end set. Runs saturate at eight times the line length. A byte
// passes from the input register to the result buffer, and the output
// register then sends its runs, one per cycle while out_stall is low; a
// byte yields up to 9 runs, and bytes without a colour change stream at
// one per cycle while out_stall is low.
module bilevel_line_run_length_extractor_core #(
  parameter int MAX_LINE_BYTES = blre_pkg::DEF_MAX_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [blre_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [blre_pkg::BYTE_W-1:0] in_pixel_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [blre_pkg::RUN_W-1:0]  out_run_length,
  output logic                        out_run_color,
  output logic                        out_line_end
);

  localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);
  localparam int CMP_W = (LEN_W > blre_pkg::CFG_W) ? LEN_W : blre_pkg::CFG_W;
  localparam int CAP_W = (LEN_W + 3 > blre_pkg::RUN_W) ? LEN_W + 3 : blre_pkg::RUN_W;

  logic [blre_pkg::CFG_W-1:0]  line_bytes_r;
  logic [blre_pkg::BYTE_W-1:0] byte_r;
  logic                        byte_valid_r;
  logic [blre_pkg::RUN_W-1:0]  run_count_r;
  logic [blre_pkg::RUN_W-1:0]  run_count_nxt;
  logic                        run_color_r;
  logic                        run_color_nxt;
  logic [LEN_W-1:0]            byte_pos_r;
  logic [LEN_W-1:0]            byte_pos_nxt;
  logic [CMP_W-1:0]            lb_ext;
  logic [LEN_W-1:0]            line_len;
  logic [CAP_W-1:0]            cap_ext;
  logic [blre_pkg::RUN_W-1:0]  run_cap;
  blre_pkg::run_t              runs [blre_pkg::MAX_RUNS];
  logic [blre_pkg::CNT_W-1:0]  run_num;
  logic                        take;
  logic                        in_acc;

  assign lb_ext = CMP_W'(line_bytes_r);

  always_comb begin
    if (lb_ext == '0) begin
      line_len = LEN_W'(1);
    end else if (lb_ext > CMP_W'(MAX_LINE_BYTES)) begin
      line_len = LEN_W'(MAX_LINE_BYTES);
    end else begin
      line_len = lb_ext[LEN_W-1:0];
    end
  end

  assign cap_ext = CAP_W'({line_len, 3'b000});
  assign run_cap = (cap_ext > CAP_W'(blre_pkg::RUN_MAX)) ? blre_pkg::RUN_MAX
                                                         : cap_ext[blre_pkg::RUN_W-1:0];

  assign in_stall = byte_valid_r && !take;
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= blre_pkg::LINE_BYTES_RESET;
    end else if (cfg_we) begin
      line_bytes_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_acc) begin
      byte_valid_r <= 1'b1;
    end else if (take) begin
      byte_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_pixel_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r <= '0;
      run_color_r <= 1'b0;
      byte_pos_r <= '0;
    end else if (take) begin
      run_count_r <= run_count_nxt;
      run_color_r <= run_color_nxt;
      byte_pos_r <= byte_pos_nxt;
    end
  end

  blre_runs #(
    .LEN_W(LEN_W)
  ) u_runs (
    .pixel_byte    (byte_r),
    .run_count     (run_count_r),
    .run_color     (run_color_r),
    .byte_pos      (byte_pos_r),
    .line_len      (line_len),
    .run_cap       (run_cap),
    .runs          (runs),
    .run_num       (run_num),
    .run_count_nxt (run_count_nxt),
    .run_color_nxt (run_color_nxt),
    .byte_pos_nxt  (byte_pos_nxt)
  );

  blre_drain u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld_valid       (byte_valid_r),
    .ld_runs        (runs),
    .ld_num         (run_num),
    .ld_take        (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_length (out_run_length),
    .out_run_color  (out_run_color),
    .out_line_end   (out_line_end)
  );

endmodule

FILE: hw/rtl/blre_runs.sv
// ----------------------------------------------------------------------------
// blre_runs: run finder for one pixel byte
// Walks the eight pixels of a byte from the open run state and lists every
// closed run, plus the final run when the byte completes the line.
// ----------------------------------------------------------------------------
module blre_runs #(
  parameter int LEN_W = 11
) (
  input  logic [blre_pkg::BYTE_W-1:0] pixel_byte,
  input  logic [blre_pkg::RUN_W-1:0]  run_count,
  input  logic                        run_color,
  input  logic [LEN_W-1:0]            byte_pos,
  input  logic [LEN_W-1:0]            line_len,
  input  logic [blre_pkg::RUN_W-1:0]  run_cap,
  output blre_pkg::run_t              runs [blre_pkg::MAX_RUNS],
  output logic [blre_pkg::CNT_W-1:0]  run_num,
  output logic [blre_pkg::RUN_W-1:0]  run_count_nxt,
  output logic                        run_color_nxt,
  output logic [LEN_W-1:0]            byte_pos_nxt
);

  logic [LEN_W-1:0] pos_inc;

  assign pos_inc = byte_pos + LEN_W'(1);

  always_comb begin
    logic [blre_pkg::RUN_W-1:0] rc;
    logic                       col;
    logic [blre_pkg::CNT_W-1:0] n;
    rc = run_count;
    col = run_color;
    n = '0;
    for (int k = 0; k < blre_pkg::MAX_RUNS; k++) begin
      runs[k] = '0;
    end
    for (int i = blre_pkg::BYTE_W - 1; i >= 0; i--) begin
      if (pixel_byte[i] == col) begin
        if (rc < run_cap) begin
          rc = rc + blre_pkg::RUN_W'(1);
        end
      end else begin
        runs[n[blre_pkg::PTR_W-1:0]] = '{length: rc, color: col, last: 1'b0};
        n = n + blre_pkg::CNT_W'(1);
        rc = blre_pkg::RUN_W'(1);
        col = pixel_byte[i];
      end
    end
    if (pos_inc >= line_len) begin
      runs[n[blre_pkg::PTR_W-1:0]] = '{length: rc, color: col, last: 1'b1};
      n = n + blre_pkg::CNT_W'(1);
      rc = '0;
      col = 1'b0;
      byte_pos_nxt = '0;
    end else begin
      byte_pos_nxt = pos_inc;
    end
    run_num = n;
    run_count_nxt = rc;
    run_color_nxt = col;
  end

endmodule

FILE: hw/rtl/blre_drain.sv
// ----------------------------------------------------------------------------
// blre_drain: result buffer and output register
// Holds one byte's runs and sends one beat per cycle while out_stall is low.
// A new batch is taken in the cycle its predecessor's last run leaves.
// ----------------------------------------------------------------------------
module blre_drain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ld_valid,
  input  blre_pkg::run_t              ld_runs [blre_pkg::MAX_RUNS],
  input  logic [blre_pkg::CNT_W-1:0]  ld_num,
  output logic                        ld_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [blre_pkg::RUN_W-1:0]  out_run_length,
  output logic                        out_run_color,
  output logic                        out_line_end
);

  blre_pkg::run_t             runs_r [blre_pkg::MAX_RUNS];
  logic [blre_pkg::CNT_W-1:0] num_r;
  logic [blre_pkg::CNT_W-1:0] ptr_r;
  logic [blre_pkg::CNT_W-1:0] ptr_nxt;
  logic                       has_run;
  logic                       out_load;
  logic                       out_valid_r;
  blre_pkg::run_t             out_r;

  assign has_run = ptr_r != num_r;
  assign out_load = has_run && (!out_valid_r || !out_stall);
  assign ptr_nxt = ptr_r + blre_pkg::CNT_W'(out_load);
  assign ld_take = ld_valid && (ptr_nxt == num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
      ptr_r <= '0;
    end else if (ld_take) begin
      num_r <= ld_num;
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_take) begin
      runs_r <= ld_runs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= runs_r[ptr_r[blre_pkg::PTR_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_run_length = out_r.length;
  assign out_run_color = out_r.color;
  assign out_line_end = out_r.last;

endmodule
